// File: hw/rtl/infix_expression_evaluator_unit_assert.svh
// assertion macros for the infix expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define IEE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("iee assertion failed");

// next-cycle implication
`define IEE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("iee assertion failed");

`endif

// File: hw/rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// types, codes and tables shared by the expression evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iee_pkg;

	localparam int VALUE_DEPTH_DEF    = 16;
	localparam int OPERATOR_DEPTH_DEF = 16;

	localparam logic [2:0] OP_END = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd2;
	localparam logic [2:0] OP_SUB = 3'd3;
	localparam logic [2:0] OP_MUL = 3'd4;
	localparam logic [2:0] OP_DIV = 3'd5;
	localparam logic [2:0] OP_LPAR = 3'd6;
	localparam logic [2:0] OP_RPAR = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BADCHAR   = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ACT, S_RED, S_RED_CHK, S_APPLY, S_APPLY_Y, S_APPLY_X,
		S_DIV, S_WB, S_RED_DONE, S_CHKLAST, S_ENDNUM, S_ENDRED, S_FINAL, S_EMIT
	} state_t;

	function automatic logic [5:0] prec(input logic [2:0] op);
		logic [5:0] p;
		case (op)
			OP_ADD, OP_SUB: p = 6'd10;
			OP_MUL, OP_DIV: p = 6'd50;
			OP_LPAR, OP_RPAR: p = 6'd5;
			default: p = 6'd0;
		endcase
		return p;
	endfunction

endpackage

// File: hw/rtl/iee_stack_mem.sv
// ----------------------------------------------------------------------------
// iee_stack_mem
// stack storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_stack_mem #(
	parameter int WIDTH = 32,
	parameter int DEPTH = iee_pkg::VALUE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/iee_divider.sv
// ----------------------------------------------------------------------------
// iee_divider
// signed 32-bit restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'd0 - dividend : dividend;
			den_q <= divisor[31] ? 32'd0 - divisor : divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? 32'd0 - quo_q : quo_q;

endmodule

// File: hw/rtl/infix_expression_evaluator_unit.sv
// An expression request carries one ASCII character (digit, space, + - * / or
// parentheses) and a last flag; one result with value and status leaves after
// each last character. Values and operators sit in two stack memories, each
// with one write port and a registered read port. A digit is folded into the
// number in the decode state; any other character goes on to the action state,
// and an operator first reduces the operator stack, applying each operator it
// pops, a divide in the iterative divider. The end of an expression pushes any
// pending number and reduces. A new request is taken while a result waits on the output.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// shunting-yard evaluator of integer infix expressions, one character a request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_expression_evaluator_unit #(
	parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
	parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  iee_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output iee_pkg::out_t  out_data
);

	localparam int VCW = $clog2(VALUE_DEPTH + 1);
	localparam int VAW = $clog2(VALUE_DEPTH);
	localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
	localparam int OAW = $clog2(OPERATOR_DEPTH);

	iee_pkg::state_t state_q, state_d;
	logic [7:0]    ch_q, ch_d;
	logic          last_q, last_d;
	logic [31:0]   acc_q, acc_d;
	logic          innum_q, innum_d;
	logic [2:0]    err_q, err_d;
	logic [VCW-1:0] vcnt_q, vcnt_d;
	logic [OCW-1:0] ocnt_q, ocnt_d;
	logic [2:0]    nop_q, nop_d;
	logic [2:0]    top_q, top_d;
	logic          match_q, match_d;
	logic [31:0]   y_q, y_d;
	logic [31:0]   r_q, r_d;
	logic          out_valid_q, out_valid_d;
	iee_pkg::out_t out_q, out_d;

	logic           v_we, v_re, o_we, o_re;
	logic [VAW-1:0] v_waddr, v_raddr;
	logic [31:0]    v_wdata, v_rdata;
	logic [OAW-1:0] o_waddr, o_raddr;
	logic [2:0]     o_wdata, o_rdata;
	logic           div_start, div_done;
	logic [31:0]    div_q;
	logic [VCW-1:0] vm1, vm2;
	logic [OCW-1:0] om1;

	assign vm1 = vcnt_q - VCW'(1);
	assign vm2 = vcnt_q - VCW'(2);
	assign om1 = ocnt_q - OCW'(1);

	iee_stack_mem #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vstack (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.re(v_re), .raddr(v_raddr), .rdata(v_rdata)
	);

	iee_stack_mem #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_ostack (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.re(o_re), .raddr(o_raddr), .rdata(o_rdata)
	);

	iee_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(v_rdata), .divisor(y_q), .done(div_done), .quotient(div_q)
	);

	assign in_ready  = (state_q == iee_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iee_pkg::S_IDLE;
			acc_q       <= '0;
			innum_q     <= 1'b0;
			err_q       <= iee_pkg::ST_OK;
			vcnt_q      <= '0;
			ocnt_q      <= '0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			acc_q       <= acc_d;
			innum_q     <= innum_d;
			err_q       <= err_d;
			vcnt_q      <= vcnt_d;
			ocnt_q      <= ocnt_d;
			match_q     <= match_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ch_q   <= ch_d;
		last_q <= last_d;
		nop_q  <= nop_d;
		top_q  <= top_d;
		y_q    <= y_d;
		r_q    <= r_d;
		out_q  <= out_d;
	end

	always_comb begin
		state_d = state_q;
		ch_d = ch_q;
		last_d = last_q;
		acc_d = acc_q;
		innum_d = innum_q;
		err_d = err_q;
		vcnt_d = vcnt_q;
		ocnt_d = ocnt_q;
		nop_d = nop_q;
		top_d = top_q;
		match_d = match_q;
		y_d = y_q;
		r_d = r_q;
		out_d = out_q;
		out_valid_d = out_valid_q && !out_ready;
		v_we = 1'b0;
		v_waddr = vcnt_q[VAW-1:0];
		v_wdata = acc_q;
		v_re = 1'b0;
		v_raddr = vm1[VAW-1:0];
		o_we = 1'b0;
		o_waddr = ocnt_q[OAW-1:0];
		o_wdata = nop_q;
		o_re = 1'b0;
		o_raddr = om1[OAW-1:0];
		div_start = 1'b0;

		case (state_q)
			iee_pkg::S_IDLE: begin
				if (in_valid) begin
					ch_d = in_data.char_code;
					last_d = in_data.last;
					state_d = iee_pkg::S_DECODE;
				end
			end
			iee_pkg::S_DECODE: begin
				if (err_q != iee_pkg::ST_OK) begin
					state_d = iee_pkg::S_CHKLAST;
				end else if (ch_q >= iee_pkg::CH_0 && ch_q <= iee_pkg::CH_9) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, ch_q[3:0]};
					innum_d = 1'b1;
					state_d = iee_pkg::S_CHKLAST;
				end else begin
					if (innum_q) begin
						if (vcnt_q == VCW'(VALUE_DEPTH)) begin
							err_d = iee_pkg::ST_OVERFLOW;
						end else begin
							v_we = 1'b1;
							vcnt_d = vcnt_q + VCW'(1);
						end
						acc_d = '0;
						innum_d = 1'b0;
					end
					state_d = iee_pkg::S_ACT;
				end
			end
			iee_pkg::S_ACT: begin
				state_d = iee_pkg::S_CHKLAST;
				match_d = 1'b0;
				if (err_q == iee_pkg::ST_OK) begin
					case (ch_q)
						iee_pkg::CH_SPACE: ;
						iee_pkg::CH_PLUS: begin
							nop_d = iee_pkg::OP_ADD;
							state_d = iee_pkg::S_RED;
						end
						iee_pkg::CH_MINUS: begin
							nop_d = iee_pkg::OP_SUB;
							state_d = iee_pkg::S_RED;
						end
						iee_pkg::CH_STAR: begin
							nop_d = iee_pkg::OP_MUL;
							state_d = iee_pkg::S_RED;
						end
						iee_pkg::CH_SLASH: begin
							nop_d = iee_pkg::OP_DIV;
							state_d = iee_pkg::S_RED;
						end
						iee_pkg::CH_RPAR: begin
							nop_d = iee_pkg::OP_RPAR;
							state_d = iee_pkg::S_RED;
						end
						iee_pkg::CH_LPAR: begin
							if (ocnt_q == OCW'(OPERATOR_DEPTH)) begin
								err_d = iee_pkg::ST_OVERFLOW;
							end else begin
								o_we = 1'b1;
								o_wdata = iee_pkg::OP_LPAR;
								ocnt_d = ocnt_q + OCW'(1);
							end
						end
						default: err_d = iee_pkg::ST_BADCHAR;
					endcase
				end
			end
			iee_pkg::S_RED: begin
				if (ocnt_q == '0 || err_q != iee_pkg::ST_OK) begin
					state_d = iee_pkg::S_RED_DONE;
				end else begin
					o_re = 1'b1;
					state_d = iee_pkg::S_RED_CHK;
				end
			end
			iee_pkg::S_RED_CHK: begin
				state_d = iee_pkg::S_RED_DONE;
				if (o_rdata == iee_pkg::OP_LPAR) begin
					if (nop_q == iee_pkg::OP_RPAR) begin
						ocnt_d = om1;
						match_d = 1'b1;
					end
				end else if (iee_pkg::prec(o_rdata) >= iee_pkg::prec(nop_q)) begin
					ocnt_d = om1;
					top_d = o_rdata;
					state_d = iee_pkg::S_APPLY;
				end
			end
			iee_pkg::S_APPLY: begin
				if (vcnt_q < VCW'(2)) begin
					err_d = iee_pkg::ST_MALFORMED;
					state_d = iee_pkg::S_RED;
				end else begin
					v_re = 1'b1;
					state_d = iee_pkg::S_APPLY_Y;
				end
			end
			iee_pkg::S_APPLY_Y: begin
				y_d = v_rdata;
				v_re = 1'b1;
				v_raddr = vm2[VAW-1:0];
				state_d = iee_pkg::S_APPLY_X;
			end
			iee_pkg::S_APPLY_X: begin
				state_d = iee_pkg::S_WB;
				case (top_q)
					iee_pkg::OP_ADD: r_d = v_rdata + y_q;
					iee_pkg::OP_SUB: r_d = v_rdata - y_q;
					iee_pkg::OP_MUL: r_d = v_rdata * y_q;
					default: begin
						if (y_q == '0) begin
							err_d = iee_pkg::ST_DIVZERO;
							state_d = iee_pkg::S_RED;
						end else begin
							div_start = 1'b1;
							state_d = iee_pkg::S_DIV;
						end
					end
				endcase
			end
			iee_pkg::S_DIV: begin
				if (div_done) begin
					r_d = div_q;
					state_d = iee_pkg::S_WB;
				end
			end
			iee_pkg::S_WB: begin
				v_we = 1'b1;
				v_waddr = vm2[VAW-1:0];
				v_wdata = r_q;
				vcnt_d = vm1;
				state_d = iee_pkg::S_RED;
			end
			iee_pkg::S_RED_DONE: begin
				state_d = (nop_q == iee_pkg::OP_END) ? iee_pkg::S_FINAL : iee_pkg::S_CHKLAST;
				if (err_q == iee_pkg::ST_OK) begin
					if (nop_q == iee_pkg::OP_RPAR) begin
						if (!match_q) begin
							err_d = iee_pkg::ST_MALFORMED;
						end
					end else if (nop_q == iee_pkg::OP_END) begin
						if (ocnt_q != '0) begin
							err_d = iee_pkg::ST_MALFORMED;
						end
					end else if (ocnt_q == OCW'(OPERATOR_DEPTH)) begin
						err_d = iee_pkg::ST_OVERFLOW;
					end else begin
						o_we = 1'b1;
						ocnt_d = ocnt_q + OCW'(1);
					end
				end
			end
			iee_pkg::S_CHKLAST: begin
				state_d = last_q ? iee_pkg::S_ENDNUM : iee_pkg::S_IDLE;
			end
			iee_pkg::S_ENDNUM: begin
				if (err_q == iee_pkg::ST_OK && innum_q) begin
					if (vcnt_q == VCW'(VALUE_DEPTH)) begin
						err_d = iee_pkg::ST_OVERFLOW;
					end else begin
						v_we = 1'b1;
						vcnt_d = vcnt_q + VCW'(1);
					end
					innum_d = 1'b0;
				end
				state_d = iee_pkg::S_ENDRED;
			end
			iee_pkg::S_ENDRED: begin
				nop_d = iee_pkg::OP_END;
				match_d = 1'b0;
				state_d = (err_q == iee_pkg::ST_OK) ? iee_pkg::S_RED : iee_pkg::S_FINAL;
			end
			iee_pkg::S_FINAL: begin
				if (err_q == iee_pkg::ST_OK && vcnt_q != VCW'(1)) begin
					err_d = iee_pkg::ST_MALFORMED;
				end
				v_re = 1'b1;
				v_raddr = '0;
				state_d = iee_pkg::S_EMIT;
			end
			iee_pkg::S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_d.status = err_q;
					out_d.result_value = (err_q == iee_pkg::ST_OK) ? v_rdata : 32'd0;
					vcnt_d = '0;
					ocnt_d = '0;
					acc_d = '0;
					innum_d = 1'b0;
					err_d = iee_pkg::ST_OK;
					state_d = iee_pkg::S_IDLE;
				end
			end
			default: state_d = iee_pkg::S_IDLE;
		endcase
	end

`include "infix_expression_evaluator_unit_assert.svh"

	`IEE_ASSERT_NOW(a_vcnt_bound, clk, arst_n, 1'b1, vcnt_q <= VCW'(VALUE_DEPTH))
	`IEE_ASSERT_NOW(a_ocnt_bound, clk, arst_n, 1'b1, ocnt_q <= OCW'(OPERATOR_DEPTH))
	`IEE_ASSERT_NOW(a_err_zero, clk, arst_n,
		out_valid && out_data.status != iee_pkg::ST_OK, out_data.result_value == 32'sd0)
	`IEE_ASSERT_NEXT(a_err_sticky, clk, arst_n,
		state_q != iee_pkg::S_EMIT && err_q != iee_pkg::ST_OK, err_q == $past(err_q))

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// character-stream bench for the infix evaluator: directed and random
// expressions go in one request at a time, a scoreboard checks value and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import iee_pkg::*;

	localparam int VDEPTH = VALUE_DEPTH_DEF;
	localparam int ODEPTH = OPERATOR_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	always #1 clk = ~clk;

	infix_expression_evaluator_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// evaluator state
	logic [31:0] vals[VDEPTH];
	int unsigned vcnt;
	logic [2:0] ops[ODEPTH];
	int unsigned ocnt;
	logic [31:0] acc;
	bit innum;
	logic [2:0] err;

	in_t pending[$];
	out_t expected_results[$];
	int idle_pct = 0, stall_pct = 0;
	bit hold_sender = 1'b0;
	bit stim_done = 1'b0;
	int mismatches = 0, results_seen = 0, requests_sent = 0;
	int quiet = 0;
	bit accepted_last = 1'b0;

	function automatic int unsigned op_prec(logic [2:0] op);
		case (op)
			OP_ADD, OP_SUB: return 10;
			OP_MUL, OP_DIV: return 50;
			OP_LPAR, OP_RPAR: return 5;
			default: return 0;
		endcase
	endfunction

	function automatic void clear_eval();
		vcnt = 0; ocnt = 0; acc = '0; innum = 1'b0; err = ST_OK;
	endfunction

	function automatic void flag(logic [2:0] code);
		if (err == ST_OK) err = code;
	endfunction

	function automatic void push_val(logic [31:0] v);
		if (vcnt >= VDEPTH) flag(ST_OVERFLOW);
		else begin
			vals[vcnt] = v;
			vcnt++;
		end
	endfunction

	function automatic void push_op(logic [2:0] op);
		if (ocnt >= ODEPTH) flag(ST_OVERFLOW);
		else begin
			ops[ocnt] = op;
			ocnt++;
		end
	endfunction

	function automatic void apply_op(logic [2:0] op);
		logic [31:0] x, y, r, ax, ay, q;
		if (vcnt < 2) begin
			flag(ST_MALFORMED);
			return;
		end
		y = vals[vcnt-1];
		x = vals[vcnt-2];
		case (op)
			OP_ADD: r = x + y;
			OP_SUB: r = x - y;
			OP_MUL: r = x * y;
			default: begin
				if (y == 0) begin
					flag(ST_DIVZERO);
					return;
				end
				ax = x[31] ? -x : x;
				ay = y[31] ? -y : y;
				q = ax / ay;
				r = (x[31] != y[31]) ? -q : q;
			end
		endcase
		vcnt--;
		vals[vcnt-1] = r;
	endfunction

	function automatic void reduce_to(logic [2:0] nxt);
		bit matched;
		logic [2:0] top;
		matched = 1'b0;
		while (ocnt > 0 && err == ST_OK) begin
			top = ops[ocnt-1];
			if (top == OP_LPAR) begin
				if (nxt == OP_RPAR) begin
					ocnt--;
					matched = 1'b1;
				end
				break;
			end
			if (op_prec(top) >= op_prec(nxt)) begin
				ocnt--;
				apply_op(top);
			end else break;
		end
		if (err != ST_OK) return;
		if (nxt == OP_RPAR && !matched) flag(ST_MALFORMED);
		if (nxt == OP_END && ocnt != 0) flag(ST_MALFORMED);
	endfunction

	// returns 1 and fills res when the character closes an expression
	function automatic bit eval_char(in_t it, output out_t res);
		logic [7:0] c;
		logic [2:0] op;
		c = it.char_code;
		res = '0;
		if (err == ST_OK) begin
			if (c >= CH_0 && c <= CH_9) begin
				acc = acc * 32'd10 + 32'(c - CH_0);
				innum = 1'b1;
			end else begin
				if (innum) begin
					push_val(acc);
					acc = '0;
					innum = 1'b0;
				end
				if (err == ST_OK) begin
					case (c)
						CH_SPACE: ;
						CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
							op = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
								(c == CH_STAR) ? OP_MUL : OP_DIV;
							reduce_to(op);
							if (err == ST_OK) push_op(op);
						end
						CH_LPAR: push_op(OP_LPAR);
						CH_RPAR: reduce_to(OP_RPAR);
						default: flag(ST_BADCHAR);
					endcase
				end
			end
		end
		if (!it.last) return 1'b0;
		if (err == ST_OK && innum) begin
			push_val(acc);
			innum = 1'b0;
		end
		if (err == ST_OK) reduce_to(OP_END);
		if (err == ST_OK && vcnt != 1) flag(ST_MALFORMED);
		if (err == ST_OK) begin
			res.result_value = vals[0];
			res.status = ST_OK;
		end else begin
			res.result_value = '0;
			res.status = err;
		end
		clear_eval();
		return 1'b1;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_last) begin
				if (pending.size() > 0 && !hold_sender &&
					$urandom_range(99) >= idle_pct) begin
					in_data <= pending.pop_front();
					in_valid <= 1'b1;
				end else in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	out_t got;
	always @(posedge clk) begin
		accepted_last <= in_valid && in_ready;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (in_valid && in_ready) begin
				requests_sent <= requests_sent + 1;
				if (eval_char(in_data, got)) expected_results.push_back(got);
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result value=%0d status=%0d",
							out_data.result_value, out_data.status);
				end else begin
					got = expected_results.pop_front();
					if (got.result_value !== out_data.result_value ||
						got.status !== out_data.status) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: exp value=%0d status=%0d, got value=%0d status=%0d",
								got.result_value, got.status,
								out_data.result_value, out_data.status);
					end
				end
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", quiet);
				$display("** infix_expression_evaluator_unit: FAILED **");
				$finish;
			end
		end
	end

	// stimulus helpers
	function automatic void add_str(string s);
		in_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.char_code = s[i];
			it.last = (i == s.len() - 1);
			pending.push_back(it);
		end
	endfunction

	function automatic string rand_num();
		int n;
		string s;
		n = $urandom_range(3) == 0 ? $urandom_range(12, 1) : $urandom_range(3, 1);
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
		return s;
	endfunction

	function automatic string rand_expr(int depth);
		string s, opc;
		int terms;
		terms = $urandom_range(4, 1);
		s = "";
		for (int t = 0; t < terms; t++) begin
			if (t > 0) begin
				case ($urandom_range(3))
					0: opc = "+";
					1: opc = "-";
					2: opc = "*";
					default: opc = "/";
				endcase
				if ($urandom_range(2) == 0) s = {s, " "};
				s = {s, opc};
				if ($urandom_range(2) == 0) s = {s, " "};
			end
			if (depth < 5 && $urandom_range(3) == 0) s = {s, "(", rand_expr(depth + 1), ")"};
			else s = {s, rand_num()};
		end
		return s;
	endfunction

	function automatic string mangle(string s);
		int p;
		logic [7:0] c;
		p = (s.len() > 0) ? $urandom_range(s.len() - 1) : 0;
		case ($urandom_range(3))
			0: c = 8'($urandom_range(255));
			1: c = CH_RPAR;
			2: c = CH_LPAR;
			default: c = CH_STAR;
		endcase
		if (s.len() == 0) return string'(c);
		s[p] = c;
		return s;
	endfunction

	task automatic run_phase(int idle, int stall, int count);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = requests_sent;
		while (requests_sent - start < count) begin
			if (pending.size() < 40) begin
				if ($urandom_range(9) < 8) add_str(rand_expr(0));
				else add_str(mangle(rand_expr(0)));
			end
			@(posedge clk);
		end
	endtask

	initial begin
		in_t it;
		clear_eval();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		add_str("0");
		add_str("4294967295");
		add_str("99999999999");
		add_str("2147483647+1");
		add_str("7 - 10 * 3 / 2");
		add_str("(1+2)*(3-4)/ 5 ");
		add_str("0-2147483648/(0-1)");
		add_str("-7/2");
		add_str("0-7/2");
		add_str("5/0");
		add_str("1+a");
		add_str("1+");
		add_str("1)");
		add_str("(1");
		add_str("  ");
		add_str("1 2");
		add_str("((((((((((((((((((1))))))))))))))))))");
		add_str("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
		add_str("1+(2*(3+(4*(5+(6*(7+(8*(9+1))))))))");
		for (int c = 0; c < 256; c++) begin
			it.char_code = 8'(c);
			it.last = 1'b1;
			pending.push_back(it);
		end
		it.last = 1'b0; it.char_code = 8'hff;
		pending.push_back(it);
		add_str("3");
		while (pending.size() > 0) @(posedge clk);
		// hold off until the block has drained
		hold_sender = 1'b1;
		while (expected_results.size() > 0) @(posedge clk);
		hold_sender = 1'b0;
		run_phase(0, 0, 300);
		run_phase(81, 0, 280);
		run_phase(0, 81, 280);
		run_phase(28, 28, 250);
		hold_sender = 1'b1;
		while (expected_results.size() > 0 || in_valid) @(posedge clk);
		hold_sender = 1'b0;
		run_phase(0, 0, 120);
		while (pending.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d character requests and %0d expressions, incl. error cases",
			requests_sent, results_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** infix_expression_evaluator_unit: PASSED **");
		else
			$display("** infix_expression_evaluator_unit: FAILED **");
		$finish;
	end
endmodule

// File: infix_expression_evaluator_unit.f
+incdir+hw/rtl
hw/rtl/iee_pkg.sv
hw/rtl/iee_stack_mem.sv
hw/rtl/iee_divider.sv
hw/rtl/infix_expression_evaluator_unit.sv
bench/tb_top.sv
